[hw/rtl/sdiv_pkg.sv]
// sdiv_pkg: shared types and constants for the serial clock divider search
// no dependencies
package sdiv_pkg;

   typedef logic [31:0] rate_type;
   typedef logic [7:0]  div8_type;

   localparam div8_type PRESCALE_MIN     = 8'h02;
   localparam div8_type PRESCALE_MAX     = 8'hFE;
   localparam div8_type FACTOR_MIN       = 8'h00;
   localparam div8_type FACTOR_MAX       = 8'hFF;

   // largest divisor, prescale max times factor max plus one
   localparam logic [15:0] MIN_RATE_DIVISOR = 16'd65024;

   localparam rate_type INPUT_RATE_RESET = 32'd100000000;

endpackage

[hw/rtl/sdiv_if.sv]
// sdiv_if: valid/ready channel interfaces for request and response transactions
// depends on sdiv_pkg
interface sdiv_req_if
   import sdiv_pkg::*;
   ();
   logic     valid;
   logic     ready;
   rate_type requested_rate;

   modport source (output valid, output requested_rate, input ready);
   modport sink   (input valid, input requested_rate, output ready);
endinterface

interface sdiv_rsp_if
   import sdiv_pkg::*;
   ();
   logic     valid;
   logic     ready;
   logic     status;
   logic     above_max;
   div8_type prescale_divisor;
   div8_type rate_factor;
   rate_type achieved_rate;

   modport source (output valid, output status, output above_max, output prescale_divisor,
                   output rate_factor, output achieved_rate, input ready);
   modport sink   (input valid, input status, input above_max, input prescale_divisor,
                   input rate_factor, input achieved_rate, output ready);
endinterface

[hw/rtl/serial_clock_divider_search_top.sv]
// serial_clock_divider_search_top: prescale and rate factor search with a bit-serial divider
// depends on sdiv_pkg and sdiv_if
//
//   channel   direction  handshake          payload
//   req_bus   in         valid/ready        requested_rate
//   rsp_bus   out        valid/ready        status, above_max, prescale_divisor,
//                                           rate_factor, achieved_rate
//   csr       in         csr_wr_en          csr_wr_data (input clock rate)
//
// one search at a time; every division is restoring, one quotient bit per cycle;
// each search division runs the divisor multiply, the quotient bit steps and an evaluation
// the minimum rate check comes first, with no multiply, then 9 divisions per
// prescale (8 binary search probes over the factor plus one final division),
// up to 127 prescales, fewer on an exact match
// the error case finishes after the first division
// synchronous active high reset returns to idle and loads the input rate of 100 MHz
// a stalled response waits in the output register while the next search runs; that search
// then holds in emit, with request ready low, until the output register frees
module serial_clock_divider_search_top
   import sdiv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  rate_type   csr_wr_data,
   sdiv_req_if.sink   req_bus,
   sdiv_rsp_if.source rsp_bus
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_EVAL,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_MIN,
      PH_PROBE,
      PH_FINAL
   } phase_type;

   // control
   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [2:0]  bit_ff, bit_in;
   rate_type    clk_rate_ff, clk_rate_in;

   // divider datapath
   rate_type    quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;

   // search datapath
   rate_type    req_ff, req_in;
   div8_type    pre_ff, pre_in;
   div8_type    pos_ff, pos_in;
   div8_type    fac_ff, fac_in;
   rate_type    best_rate_ff, best_rate_in;
   div8_type    best_pre_ff, best_pre_in;
   div8_type    best_fac_ff, best_fac_in;
   logic        status_ff, status_in;
   logic        above_ff, above_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff, rsp_status_in;
   logic        rsp_above_ff, rsp_above_in;
   div8_type    rsp_pre_ff, rsp_pre_in;
   div8_type    rsp_fac_ff, rsp_fac_in;
   rate_type    rsp_rate_ff, rsp_rate_in;

   // divider step: shift in the next dividend bit and try to subtract
   logic [16:0] shifted;
   logic [17:0] diff;
   logic [16:0] product;
   logic        fits;
   logic        hit;
   div8_type    pos_next;
   logic [2:0]  bit_next;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign product = 17'(pre_ff) * 17'({1'b0, fac_ff} + 9'd1);

   // rate from the last division is in quo_ff
   assign fits     = (quo_ff <= req_ff);
   assign hit      = fits && (quo_ff > best_rate_ff);
   assign pos_next = fits ? pos_ff : (pos_ff | (8'd1 << bit_ff));
   assign bit_next = bit_ff - 3'd1;

   assign req_bus.ready            = (state_ff == S_IDLE);
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_status_ff;
   assign rsp_bus.above_max        = rsp_above_ff;
   assign rsp_bus.prescale_divisor = rsp_pre_ff;
   assign rsp_bus.rate_factor      = rsp_fac_ff;
   assign rsp_bus.achieved_rate    = rsp_rate_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      bit_in       = bit_ff;
      clk_rate_in  = clk_rate_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      req_in       = req_ff;
      pre_in       = pre_ff;
      pos_in       = pos_ff;
      fac_in       = fac_ff;
      best_rate_in = best_rate_ff;
      best_pre_in  = best_pre_ff;
      best_fac_in  = best_fac_ff;
      status_in    = status_ff;
      above_in     = above_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_above_in  = rsp_above_ff;
      rsp_pre_in    = rsp_pre_ff;
      rsp_fac_in    = rsp_fac_ff;
      rsp_rate_in   = rsp_rate_ff;

      if (csr_wr_en) begin
         clk_rate_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               // first division gives the minimum reachable rate
               req_in   = req_bus.requested_rate;
               den_in   = MIN_RATE_DIVISOR;
               quo_in   = clk_rate_ff;
               rem_in   = '0;
               cnt_in   = '0;
               phase_in = PH_MIN;
               state_in = S_DIV;
            end
         end
         S_MUL: begin
            den_in   = product[15:0];
            quo_in   = clk_rate_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!diff[17]) begin
               rem_in = diff[15:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = shifted[15:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            case (phase_ff)
               PH_MIN: begin
                  best_rate_in = '0;
                  best_pre_in  = '0;
                  best_fac_in  = '0;
                  if (req_ff < quo_ff) begin
                     status_in = 1'b1;
                     above_in  = 1'b0;
                     state_in  = S_EMIT;
                  end else begin
                     status_in = 1'b0;
                     above_in  = (req_ff > {1'b0, clk_rate_ff[31:1]});
                     pre_in    = PRESCALE_MIN;
                     pos_in    = FACTOR_MIN;
                     bit_in    = 3'd7;
                     fac_in    = 8'd127;
                     phase_in  = PH_PROBE;
                     state_in  = S_MUL;
                  end
               end
               PH_PROBE: begin
                  // binary search for the smallest factor that fits under the request
                  pos_in   = pos_next;
                  state_in = S_MUL;
                  if (bit_ff == 3'd0) begin
                     fac_in   = pos_next;
                     phase_in = PH_FINAL;
                  end else begin
                     bit_in = bit_next;
                     fac_in = pos_next | ((8'd1 << bit_next) - 8'd1);
                  end
               end
               PH_FINAL: begin
                  if (hit) begin
                     best_rate_in = quo_ff;
                     best_pre_in  = pre_ff;
                     best_fac_in  = pos_ff;
                  end
                  if ((hit && (quo_ff == req_ff)) || (pre_ff == PRESCALE_MAX)) begin
                     state_in = S_EMIT;
                  end else begin
                     pre_in   = pre_ff + 8'd2;
                     pos_in   = FACTOR_MIN;
                     bit_in   = 3'd7;
                     fac_in   = 8'd127;
                     phase_in = PH_PROBE;
                     state_in = S_MUL;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_EMIT: begin
            // wait here while an earlier response still sits in the output register
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_above_in  = above_ff;
               rsp_pre_in    = best_pre_ff;
               rsp_fac_in    = best_fac_ff;
               rsp_rate_in   = best_rate_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_MIN;
         cnt_ff       <= '0;
         bit_ff       <= '0;
         clk_rate_ff  <= INPUT_RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         bit_ff       <= bit_in;
         clk_rate_ff  <= clk_rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      req_ff        <= req_in;
      pre_ff        <= pre_in;
      pos_ff        <= pos_in;
      fac_ff        <= fac_in;
      best_rate_ff  <= best_rate_in;
      best_pre_ff   <= best_pre_in;
      best_fac_ff   <= best_fac_in;
      status_ff     <= status_in;
      above_ff      <= above_in;
      rsp_status_ff <= rsp_status_in;
      rsp_above_ff  <= rsp_above_in;
      rsp_pre_ff    <= rsp_pre_in;
      rsp_fac_ff    <= rsp_fac_in;
      rsp_rate_ff   <= rsp_rate_in;
   end

`ifndef ASSERT_OFF
   // an error response carries no divider setting
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |->
         (rsp_pre_ff == 8'd0 && rsp_fac_ff == 8'd0 && rsp_rate_ff == 32'd0 && !rsp_above_ff))
      else $error("error response with nonzero divider fields");

   // a nonzero achieved rate always comes with an even nonzero prescale
   a_prescale_even: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_status_ff && rsp_rate_ff != 32'd0) |->
         (!rsp_pre_ff[0] && rsp_pre_ff != 8'd0))
      else $error("response prescale odd or zero with nonzero rate");

   // the partial remainder stays below the divisor through the division
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   // a division never starts with a zero divisor
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == 5'd0) |-> (den_ff != 16'd0))
      else $error("division started with zero divisor");
`endif

endmodule

[bench/serial_clock_divider_search_top_tb.sv]
// serial_clock_divider_search_top_tb: self-checking bench for the prescale and rate factor search
// depends on sdiv_pkg, sdiv_if and serial_clock_divider_search_top
module serial_clock_divider_search_top_tb
   import sdiv_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // receiver hold-off, longer than any single search so the block backs up
   localparam int          PRESSURE_HOLD = 90000;
   // cycles allowed after the last response for anything stray to show up
   localparam int          TAIL_CYCLES   = 200;
   localparam int          REPORT_LIMIT  = 10;

   typedef struct packed {
      logic     status;
      logic     above_max;
      div8_type prescale_divisor;
      div8_type rate_factor;
      rate_type achieved_rate;
   } divider_choice_type;

   typedef struct {
      rate_type           request;
      rate_type           input_rate;
      divider_choice_type want;
   } owed_choice_type;

   // which edge-of-range requests a phase opens with
   typedef enum {PROBE_NONE, PROBE_SHORT, PROBE_FULL} probe_set_type;

   // scoreboard: predicts the divider choice for every accepted request
   // and holds it until the matching response transaction comes back
   class divider_scoreboard;
      rate_type        input_rate;
      owed_choice_type owed[$];
      int              failures;

      function new();
         input_rate = INPUT_RATE_RESET;
         failures   = 0;
      endfunction

      function void set_input_rate(rate_type rate);
         input_rate = rate;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // exhaustive search over even prescales, smallest passing factor per prescale, up to an exact match
      function divider_choice_type best_divider_for(rate_type req);
         divider_choice_type pick;
         rate_type           ceiling_rate;
         rate_type           floor_rate;
         rate_type           r;
         int unsigned        pre;
         int unsigned        fac;
         bit                 exact;
         pick         = '0;
         exact        = 1'b0;
         ceiling_rate = input_rate / 32'd2;
         floor_rate   = input_rate / 32'(MIN_RATE_DIVISOR);
         if (req < floor_rate) begin
            pick.status = 1'b1;
            return pick;
         end
         pick.above_max = (req > ceiling_rate);
         for (pre = PRESCALE_MIN; pre <= PRESCALE_MAX && !exact; pre += 2) begin
            for (fac = FACTOR_MIN; fac <= FACTOR_MAX; fac++) begin
               r = input_rate / (pre * (fac + 1));
               if (r <= req) begin
                  if (r > pick.achieved_rate) begin
                     pick.achieved_rate    = r;
                     pick.prescale_divisor = div8_type'(pre);
                     pick.rate_factor      = div8_type'(fac);
                     exact                 = (r == req);
                  end
                  break;
               end
            end
         end
         return pick;
      endfunction

      function void note_request(rate_type req);
         owed_choice_type entry;
         entry.request    = req;
         entry.input_rate = input_rate;
         entry.want       = best_divider_for(req);
         owed.push_back(entry);
      endfunction

      function void check_response(divider_choice_type got);
         owed_choice_type entry;
         if (owed.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display({"%0t: response with nothing outstanding:",
                         " st %0d above %0d pre %0d fac %0d rate %0d"},
                        $time, got.status, got.above_max, got.prescale_divisor,
                        got.rate_factor, got.achieved_rate);
            return;
         end
         entry = owed.pop_front();
         if (got.status !== entry.want.status ||
             got.above_max !== entry.want.above_max ||
             got.prescale_divisor !== entry.want.prescale_divisor ||
             got.rate_factor !== entry.want.rate_factor ||
             got.achieved_rate !== entry.want.achieved_rate) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("%0t: mismatch for request %0d at input rate %0d", $time,
                        entry.request, entry.input_rate);
               $display("   expected st %0d above %0d pre %0d fac %0d rate %0d",
                        entry.want.status, entry.want.above_max, entry.want.prescale_divisor,
                        entry.want.rate_factor, entry.want.achieved_rate);
               $display("   actual   st %0d above %0d pre %0d fac %0d rate %0d",
                        got.status, got.above_max, got.prescale_divisor,
                        got.rate_factor, got.achieved_rate);
            end
         end
      endfunction
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_wr_en;
   rate_type csr_wr_data;

   // steady turns off idling on both sides, hold_pending asks the receiver for one long hold-off
   bit       steady       = 1'b0;
   bit       hold_pending = 1'b0;

   divider_scoreboard sb = new();

   sdiv_req_if req_bus ();
   sdiv_rsp_if rsp_bus ();

   serial_clock_divider_search_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 4);
      return $urandom_range(50, 1500);
   endfunction

   // random request shaped for the current input rate
   // exact hits on a small prescale end the search early, which keeps the run short
   function automatic rate_type pick_request(rate_type clk);
      rate_type    top;
      rate_type    bottom;
      int unsigned pre;
      int unsigned fac;
      int          roll;
      top    = clk / 32'd2;
      bottom = clk / 32'(MIN_RATE_DIVISOR);
      roll   = $urandom_range(0, 99);
      if (roll < 45) begin
         pre = 2 * $urandom_range(1, 8);
         fac = $urandom_range(0, FACTOR_MAX);
         return clk / (pre * (fac + 1));
      end
      // below the slowest reachable rate, error path
      if (roll < 60 && bottom != 0)
         return $urandom_range(0, bottom - 1);
      // above the fastest rate, flagged but still searched
      if (roll < 70)
         return $urandom_range(32'hFFFF_FFFF, top);
      // anywhere in the reachable band, usually a full search
      if (roll < 90)
         return $urandom_range(top, bottom);
      // raw 32-bit values so every request bit toggles
      return $urandom;
   endfunction

   // offer one request transaction, returns at the accepting edge
   task automatic send_request(input rate_type rate);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid          = 1'b1;
      req_bus.requested_rate = rate;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // single register write, only called while the block is idle
   task automatic write_input_rate(input rate_type rate);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = rate;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.set_input_rate(rate);
   endtask

   // one configuration phase: optional write, edge probes, then random requests, then drain
   task automatic run_phase(input rate_type clk, input bit program_it,
                            input probe_set_type probes,
                            input int random_count, input bit squeeze);
      rate_type top;
      rate_type bottom;
      rate_type edge_list[9];
      rate_type short_list[3];
      top        = clk / 32'd2;
      bottom     = clk / 32'(MIN_RATE_DIVISOR);
      edge_list  = '{32'd0, 32'd1, bottom - 32'd1, bottom, bottom + 32'd1,
                     top - 32'd1, top, top + 32'd1, 32'hFFFF_FFFF};
      short_list = '{32'd0, 32'd1, 32'hFFFF_FFFF};
      if (program_it)
         write_input_rate(clk);
      if (probes == PROBE_FULL)
         foreach (edge_list[i]) send_request(edge_list[i]);
      else if (probes == PROBE_SHORT)
         foreach (short_list[i]) send_request(short_list[i]);
      // the receiver backs off while requests keep coming
      if (squeeze)
         hold_pending = 1'b1;
      repeat (random_count) send_request(pick_request(clk));
      @(negedge clock);
      req_bus.valid = 1'b0;
      // every request yields one response, so an empty scoreboard means idle
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // receiver: random stalls, stall-free while steady, one long counted hold-off on request
   initial begin
      int stall;
      stall         = 0;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending  = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (PRESSURE_HOLD - 1) @(negedge clock);
         end else if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else if (!steady && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready = 1'b0;
            stall         = pick_gap();
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // sample both channels at the rising edge, outputs settle after it
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.requested_rate);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response('{rsp_bus.status, rsp_bus.above_max, rsp_bus.prescale_divisor,
                                rsp_bus.rate_factor, rsp_bus.achieved_rate});
      end
   end

   // stimulus and final verdict
   initial begin
      req_bus.valid          = 1'b0;
      req_bus.requested_rate = '0;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // reset value of 100 MHz, with the long receiver hold-off
      run_phase(INPUT_RATE_RESET, 1'b0, PROBE_FULL, 30, 1'b1);
      // slowest nonzero input clock, every rate rounds to zero
      run_phase(32'd1, 1'b1, PROBE_SHORT, 8, 1'b0);
      // fastest input clock
      run_phase(32'hFFFF_FFFF, 1'b1, PROBE_FULL, 25, 1'b0);
      // zero input clock, run back to back with no idling
      steady = 1'b1;
      run_phase(32'd0, 1'b1, PROBE_SHORT, 5, 1'b0);
      steady = 1'b0;
      // some arbitrary input clock
      run_phase($urandom, 1'b1, PROBE_NONE, 30, 1'b0);

      // nothing owed now; give any stray response time to appear
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         $display("%0d responses never arrived", sb.pending());
      if (sb.failures == 0 && sb.pending() == 0)
         $display("serial_clock_divider_search_top_tb: clean");
      else
         $display("serial_clock_divider_search_top_tb: errors");
      $finish;
   end

   // run limit, several times the slowest correct run
   initial begin
      #80ms;
      $display("timeout with %0d responses outstanding", sb.pending());
      $display("serial_clock_divider_search_top_tb: errors");
      $finish;
   end

endmodule

[serial_clock_divider_search_top.f]
hw/rtl/sdiv_pkg.sv
hw/rtl/sdiv_if.sv
hw/rtl/serial_clock_divider_search_top.sv
bench/serial_clock_divider_search_top_tb.sv
